/* sv/vva_pkg.sv */
// Shared types, operation codes and saturation helper for the vector ALU.
`default_nettype none
package vva_pkg;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SUB    = 3'd1;
    localparam logic [2:0] OP_SCALE  = 3'd2;
    localparam logic [2:0] OP_DOT    = 3'd3;
    localparam logic [2:0] OP_CROSS  = 3'd4;
    localparam logic [2:0] OP_LENGTH = 3'd5;
    localparam logic [2:0] OP_NORM   = 3'd6;

    // width of every pre-saturation value
    localparam int SAT_W = 68;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ov;
    } sat_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] r_s;
        logic               ov;
    } pay_t;

    function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
        sat_t res;
        logic fits;
        fits    = (&v[SAT_W-1:31]) | ~(|v[SAT_W-1:31]);
        res.ov  = ~fits;
        res.val = fits ? v[31:0] : (v[SAT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        return res;
    endfunction

endpackage
`default_nettype wire

/* sv/vva_lane.sv */
// One component lane: operand select, multiply, combine, round and saturate.
`default_nettype none
module vva_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic [2:0]         op,
    input  wire logic signed [31:0] a_self,
    input  wire logic signed [31:0] b_self,
    input  wire logic signed [31:0] a_p,
    input  wire logic signed [31:0] a_q,
    input  wire logic signed [31:0] b_p,
    input  wire logic signed [31:0] b_q,
    input  wire logic signed [31:0] scale_factor,
    output logic signed [63:0]      prod,
    output vva_pkg::sat_t           comp
);
    import vva_pkg::*;

    logic signed [31:0] m0a, m0b, m1a, m1b;
    logic signed [63:0] p0_reg, p1_reg;
    logic signed [32:0] as_reg, as2_reg;
    logic signed [64:0] c_reg;
    logic [2:0]         op1_reg, op2_reg;
    sat_t               comp_reg;
    logic signed [SAT_W-1:0] half, rnd;

    always_comb
    begin
        m0a = '0;
        m0b = '0;
        m1a = '0;
        m1b = '0;
        case (op) inside
            OP_SCALE:
            begin
                m0a = a_self;
                m0b = scale_factor;
            end
            OP_DOT:
            begin
                m0a = a_self;
                m0b = b_self;
            end
            OP_CROSS:
            begin
                m0a = a_p;
                m0b = b_q;
                m1a = a_q;
                m1b = b_p;
            end
            OP_LENGTH, OP_NORM:
            begin
                m0a = a_self;
                m0b = a_self;
            end
            default:
            begin
                m0a = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        p0_reg  <= m0a * m0b;
        p1_reg  <= m1a * m1b;
        as_reg  <= (op == OP_SUB) ? (33'(a_self) - 33'(b_self)) : (33'(a_self) + 33'(b_self));
        op1_reg <= op;
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= (op1_reg == OP_CROSS) ? (65'(p0_reg) - 65'(p1_reg)) : 65'(p0_reg);
        as2_reg <= as_reg;
        op2_reg <= op1_reg;
    end

    // round half up: add half then floor
    assign half = SAT_W'(1) <<< (FRAC_BITS - 1);
    assign rnd  = (SAT_W'(c_reg) + half) >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        case (op2_reg) inside
            OP_ADD, OP_SUB:     comp_reg <= sat32(SAT_W'(as2_reg));
            OP_SCALE, OP_CROSS: comp_reg <= sat32(rnd);
            default:            comp_reg <= '0;
        endcase
    end

    assign prod = p0_reg;
    assign comp = comp_reg;

endmodule
`default_nettype wire

/* sv/vva_sqrt.sv */
// Pipelined integer square root, one result bit per stage, rounded to nearest.
`default_nettype none
module vva_sqrt (
    input  wire logic        clk,
    input  wire logic [63:0] s,
    output logic [32:0]      root
);
    localparam int STEPS = 32;

    logic [63:0] x_reg [STEPS];
    logic [63:0] r_reg [STEPS];
    logic [32:0] root_reg;

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            logic [63:0] x_in, r_in, trial;
            if (k == 0)
            begin : g_first
                assign x_in = s;
                assign r_in = '0;
            end
            else
            begin : g_next
                assign x_in = x_reg[k-1];
                assign r_in = r_reg[k-1];
            end
            assign trial = r_in + BIT;
            always_ff @(posedge clk)
            begin
                if (x_in >= trial)
                begin
                    x_reg[k] <= x_in - trial;
                    r_reg[k] <= (r_in >> 1) + BIT;
                end
                else
                begin
                    x_reg[k] <= x_in;
                    r_reg[k] <= r_in >> 1;
                end
            end
        end
    endgenerate

    // remainder above root means the true root is past the midpoint
    always_ff @(posedge clk)
    begin
        root_reg <= (x_reg[STEPS-1] > r_reg[STEPS-1]) ? 33'(r_reg[STEPS-1]) + 33'd1
                                                       : 33'(r_reg[STEPS-1]);
    end

    assign root = root_reg;

endmodule
`default_nettype wire

/* sv/vva_div.sv */
// Pipelined restoring divider for one normalize component, rounded to nearest.
`default_nettype none
module vva_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic [32:0]        len,
    input  wire logic signed [31:0] v,
    output logic signed [31:0]      q
);
    localparam int QW = FRAC_BITS + 1;
    localparam int NW = 34 + FRAC_BITS;

    logic [31:0]   mag;
    logic [NW-1:0] n0_reg;
    logic [32:0]   d0_reg;
    logic          neg0_reg, z0_reg;

    logic [NW-1:0] rem_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [32:0]   d_reg   [QW];
    logic          neg_reg [QW];
    logic          z_reg   [QW];

    assign mag = v[31] ? (32'd0 - v) : v;

    always_ff @(posedge clk)
    begin
        n0_reg   <= (NW'(mag) << FRAC_BITS) + NW'(len >> 1);
        d0_reg   <= len;
        neg0_reg <= v[31];
        z0_reg   <= (len == '0);
    end

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_step
            logic [NW-1:0] rem_in, dsh;
            logic [QW-1:0] q_in;
            logic [32:0]   d_in;
            logic          neg_in, z_in;
            if (k == 0)
            begin : g_first
                assign rem_in = n0_reg;
                assign q_in   = '0;
                assign d_in   = d0_reg;
                assign neg_in = neg0_reg;
                assign z_in   = z0_reg;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign d_in   = d_reg[k-1];
                assign neg_in = neg_reg[k-1];
                assign z_in   = z_reg[k-1];
            end
            assign dsh = NW'(d_in) << (QW - 1 - k);
            always_ff @(posedge clk)
            begin
                if (rem_in >= dsh)
                begin
                    rem_reg[k] <= rem_in - dsh;
                    q_reg[k]   <= q_in | (QW'(1) << (QW - 1 - k));
                end
                else
                begin
                    rem_reg[k] <= rem_in;
                    q_reg[k]   <= q_in;
                end
                d_reg[k]   <= d_in;
                neg_reg[k] <= neg_in;
                z_reg[k]   <= z_in;
            end
        end
    endgenerate

    // quotient never exceeds one in fixed point, so no saturation here
    always_comb
    begin
        if (z_reg[QW-1])
            q = '0;
        else if (neg_reg[QW-1])
            q = 32'sd0 - 32'(q_reg[QW-1]);
        else
            q = 32'(q_reg[QW-1]);
    end

endmodule
`default_nettype wire

/* sv/vec3_vector_alu.sv */
// Every op takes the same time from start to done; operands and results are Q16.16 by default.
// Throughput: one item per cycle; busy is always low and results never stall.
// Latency is set by the 33-stage square root pipeline (32 steps plus rounding) followed
// by the FRAC_BITS+2 stage normalize divider; shorter ops ride a matching delay line.
// Reset clears only the valid line and done; datapath registers are not reset.
`default_nettype none
module vec3_vector_alu #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         op,
    input  wire logic signed [31:0] a_x,
    input  wire logic signed [31:0] a_y,
    input  wire logic signed [31:0] a_z,
    input  wire logic signed [31:0] b_x,
    input  wire logic signed [31:0] b_y,
    input  wire logic signed [31:0] b_z,
    input  wire logic signed [31:0] scale_factor,
    output logic                    done,
    output logic signed [31:0]      result_x,
    output logic signed [31:0]      result_y,
    output logic signed [31:0]      result_z,
    output logic signed [31:0]      result_scalar,
    output logic                    overflow
);
    import vva_pkg::*;

    localparam int LS  = 33;
    localparam int DLY = 35 + FRAC_BITS;
    localparam int LAT = DLY + 4;

    logic signed [63:0] prod_x, prod_y, prod_z;
    sat_t               comp_x, comp_y, comp_z;
    logic               v1_reg, v2_reg, v3_reg;
    logic [2:0]         op1_reg, op2_reg, op3_reg;
    logic signed [31:0] ax1_reg, ay1_reg, az1_reg;
    logic signed [31:0] ax2_reg, ay2_reg, az2_reg;
    logic signed [31:0] ax3_reg, ay3_reg, az3_reg;
    logic signed [65:0] sum_reg;
    logic [63:0]        s3_reg;
    sat_t               rs3_reg;
    logic signed [SAT_W-1:0] half, rnd;
    logic [32:0]        root;
    sat_t               len_sat;
    logic signed [31:0] nq_x, nq_y, nq_z;
    pay_t               pay_reg [DLY];
    pay_t               pay_in, pay_len;
    logic [DLY-1:0]     vld_reg;
    logic               done_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg, rs_reg;
    logic               ov_reg;

    assign busy = 1'b0;

    vva_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk(clk), .op(op), .a_self(a_x), .b_self(b_x),
        .a_p(a_y), .a_q(a_z), .b_p(b_y), .b_q(b_z),
        .scale_factor(scale_factor), .prod(prod_x), .comp(comp_x)
    );
    vva_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk(clk), .op(op), .a_self(a_y), .b_self(b_y),
        .a_p(a_z), .a_q(a_x), .b_p(b_z), .b_q(b_x),
        .scale_factor(scale_factor), .prod(prod_y), .comp(comp_y)
    );
    vva_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk(clk), .op(op), .a_self(a_z), .b_self(b_z),
        .a_p(a_x), .a_q(a_y), .b_p(b_x), .b_q(b_y),
        .scale_factor(scale_factor), .prod(prod_z), .comp(comp_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start & ~busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vld_reg  <= {vld_reg[DLY-2:0], v3_reg};
            done_reg <= vld_reg[DLY-1];
        end
    end

    // merge stage: dot product or sum of squares across lanes
    always_ff @(posedge clk)
    begin
        op1_reg <= op;
        ax1_reg <= a_x;
        ay1_reg <= a_y;
        az1_reg <= a_z;
        op2_reg <= op1_reg;
        ax2_reg <= ax1_reg;
        ay2_reg <= ay1_reg;
        az2_reg <= az1_reg;
        sum_reg <= 66'(prod_x) + 66'(prod_y) + 66'(prod_z);
        op3_reg <= op2_reg;
        ax3_reg <= ax2_reg;
        ay3_reg <= ay2_reg;
        az3_reg <= az2_reg;
        s3_reg  <= sum_reg[63:0];
        rs3_reg <= (op2_reg == OP_DOT) ? sat32(rnd) : '0;
    end

    assign half = SAT_W'(1) <<< (FRAC_BITS - 1);
    assign rnd  = (SAT_W'(sum_reg) + half) >>> FRAC_BITS;

    vva_sqrt u_sqrt (
        .clk(clk), .s(s3_reg), .root(root)
    );

    always_comb
    begin
        pay_in.op  = op3_reg;
        pay_in.a_x = ax3_reg;
        pay_in.a_y = ay3_reg;
        pay_in.a_z = az3_reg;
        pay_in.r_x = comp_x.val;
        pay_in.r_y = comp_y.val;
        pay_in.r_z = comp_z.val;
        pay_in.r_s = rs3_reg.val;
        pay_in.ov  = comp_x.ov | comp_y.ov | comp_z.ov | rs3_reg.ov;
    end

    assign len_sat = sat32($signed(SAT_W'(root)));

    always_comb
    begin
        pay_len = pay_reg[LS-1];
        if (pay_reg[LS-1].op == OP_LENGTH)
        begin
            pay_len.r_s = len_sat.val;
            pay_len.ov  = len_sat.ov;
        end
    end

    always_ff @(posedge clk)
    begin
        pay_reg[0] <= pay_in;
        for (int j = 1; j < DLY; j++)
        begin
            pay_reg[j] <= (j == LS) ? pay_len : pay_reg[j-1];
        end
    end

    vva_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk(clk), .len(root), .v(pay_reg[LS-1].a_x), .q(nq_x)
    );
    vva_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk(clk), .len(root), .v(pay_reg[LS-1].a_y), .q(nq_y)
    );
    vva_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .clk(clk), .len(root), .v(pay_reg[LS-1].a_z), .q(nq_z)
    );

    always_ff @(posedge clk)
    begin
        if (pay_reg[DLY-1].op == OP_NORM)
        begin
            rx_reg <= nq_x;
            ry_reg <= nq_y;
            rz_reg <= nq_z;
        end
        else
        begin
            rx_reg <= pay_reg[DLY-1].r_x;
            ry_reg <= pay_reg[DLY-1].r_y;
            rz_reg <= pay_reg[DLY-1].r_z;
        end
        rs_reg <= pay_reg[DLY-1].r_s;
        ov_reg <= pay_reg[DLY-1].ov;
    end

    assign done          = done_reg;
    assign result_x      = rx_reg;
    assign result_y      = ry_reg;
    assign result_z      = rz_reg;
    assign result_scalar = rs_reg;
    assign overflow      = ov_reg;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transfer did not complete at the fixed latency");

    a_scalar_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_scalar != 32'sd0) |->
        (result_x == 32'sd0 && result_y == 32'sd0 && result_z == 32'sd0))
        else $error("scalar and vector results both nonzero");

    a_ov_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |->
        (result_x == 32'sh7FFF_FFFF || result_x == 32'sh8000_0000 ||
         result_y == 32'sh7FFF_FFFF || result_y == 32'sh8000_0000 ||
         result_z == 32'sh7FFF_FFFF || result_z == 32'sh8000_0000 ||
         result_scalar == 32'sh7FFF_FFFF || result_scalar == 32'sh8000_0000))
        else $error("overflow set without a saturated field");

endmodule
`default_nettype wire
